[src/abi_argument_location_allocator_top_defines.svh]
// Assertion macros used by the assertion checker of the argument allocator.
`ifndef ABI_ARGUMENT_LOCATION_ALLOCATOR_TOP_DEFINES_SVH
`define ABI_ARGUMENT_LOCATION_ALLOCATOR_TOP_DEFINES_SVH

// Checked on every rising edge once reset is released.
`define AALA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define AALA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/aala_pkg.sv]
package aala_pkg;

  localparam int MAX_STACK_SLOTS = 1024;
  localparam int MAX_ARG_SLOTS   = 64;
  localparam int FLOAT_REGS      = 16;
  localparam int GEN_REGS        = 4;

  // One placement result, last field in the lowest bits.
  typedef struct packed {
    logic       stack_overflow;
    logic [6:0] stack_slot_count;
    logic [9:0] stack_slot_index;
    logic       stack_valid;
    logic [2:0] gen_reg_count;
    logic [1:0] gen_reg_index;
    logic       gen_reg_valid;
    logic [4:0] float_reg_count;
    logic [3:0] float_reg_index;
    logic       float_reg_valid;
  } res_t;

  typedef struct packed {
    logic [15:0] float_used_mask;
    logic [2:0]  next_gen_reg;
    logic [10:0] next_stack_slot;
  } alloc_state_t;

  typedef struct packed {
    logic [6:0] slot_count;
    logic       is_float;
    logic       align_64;
  } req_t;

  typedef struct packed {
    logic       start;
    logic       align_64;
    logic [4:0] size;
  } scan_cmd_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic [3:0]  index;
    logic [15:0] window;
  } scan_stat_t;

  // Round a stack slot up to an even slot, never past the end of the stack.
  function automatic logic [10:0] align_slot(input logic [10:0] s);
    logic [11:0] a;
    a = ({1'b0, s} + 12'd1) & ~12'd1;
    return (a > 12'(MAX_STACK_SLOTS)) ? 11'(MAX_STACK_SLOTS) : a[10:0];
  endfunction

endpackage

[src/abi_argument_location_allocator_top.sv]
// Argument location allocator for a hard-float procedure call convention.
// Each input request on the in_ channel describes one call argument: its size
// in 4-byte slots, whether it is a float argument, and whether it needs 8-byte
// alignment. A flag in in_tuser starts a new call and clears all allocation
// state before the argument is placed. Each request produces exactly one
// result request on the out_ channel, giving the float registers, general
// registers and stack slots that the argument occupies.
// Sequence: the request is taken in S_IDLE. A float argument of up to sixteen
// slots first runs the register search in S_SCAN, which tests one candidate
// start position per cycle and stops at the first free run or once it has
// passed the top register. Any other argument, or a float with no free run,
// is placed in S_PLACE. The result is then staged in S_DONE. in_tready is
// high only while no request is in progress.
// The result sits in an output register; if the receiver stalls, the next
// request can still be taken and worked, and its result waits until the
// output register empties. Synchronous reset clears the used register map,
// the general register and stack pointers, and drops out_tvalid.
module abi_argument_location_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] slot_count, [7] zero
  input  logic [2:0]  in_tuser,   // [0] new_call, [1] is_float, [2] align_64
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] float_reg_valid, [4:1] float_reg_index, [9:5] float_reg_count,
  // [10] gen_reg_valid, [12:11] gen_reg_index, [15:13] gen_reg_count,
  // [16] stack_valid, [26:17] stack_slot_index, [33:27] stack_slot_count,
  // [34] stack_overflow, [39:35] zero
  output logic [39:0] out_tdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [6:0] ARG_MAX = 7'(aala_pkg::MAX_ARG_SLOTS);
  localparam logic [6:0] FR_MAX  = 7'(aala_pkg::FLOAT_REGS);

  logic [1:0]             state_r, state_nxt;
  aala_pkg::alloc_state_t st_r, st_nxt;
  aala_pkg::req_t         req_r, req_nxt;
  aala_pkg::res_t         res_r, res_nxt;
  aala_pkg::res_t         out_res_r, out_res_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  aala_pkg::scan_cmd_t    scan_cmd;
  aala_pkg::scan_stat_t   scan_stat;
  aala_pkg::res_t         place_res;
  aala_pkg::alloc_state_t place_nxt;
  logic [6:0]             in_size;

  // The search unit reads the used map after any new-call clear has landed.
  aala_fscan u_fscan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (scan_cmd),
    .used_mask (st_r.float_used_mask),
    .stat      (scan_stat)
  );

  aala_place u_place (
    .req (req_r),
    .cur (st_r),
    .res (place_res),
    .nxt (place_nxt)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_res_r};
  // Oversized arguments are clamped to the largest size handled.
  assign in_size    = (in_tdata[6:0] > ARG_MAX) ? ARG_MAX : in_tdata[6:0];

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    out_res_nxt    = out_res_r;
    out_tvalid_nxt = out_tvalid_r;
    scan_cmd       = '0;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt.slot_count = in_size;
          req_nxt.is_float   = in_tuser[1];
          req_nxt.align_64   = in_tuser[2];
          if (in_tuser[0]) begin
            st_nxt = '0;
          end
          // Float arguments that can fit the bank search it first.
          if (in_tuser[1] && in_size != 7'd0 && in_size <= FR_MAX) begin
            scan_cmd.start    = 1'b1;
            scan_cmd.align_64 = in_tuser[2];
            scan_cmd.size     = in_size[4:0];
            state_nxt         = S_SCAN;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.found) begin
            st_nxt.float_used_mask  = st_r.float_used_mask | scan_stat.window;
            res_nxt                 = '0;
            res_nxt.float_reg_valid = 1'b1;
            res_nxt.float_reg_index = scan_stat.index;
            res_nxt.float_reg_count = req_r.slot_count[4:0];
            state_nxt               = S_DONE;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        res_nxt   = place_res;
        st_nxt    = place_nxt;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_res_nxt    = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      st_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

[src/aala_fscan.sv]
// Float register run search: one candidate start position per cycle.
module aala_fscan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aala_pkg::scan_cmd_t    cmd,
  input  logic [15:0]            used_mask,
  output aala_pkg::scan_stat_t   stat
);

  logic        busy_r, busy_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [4:0]  size_r, size_nxt;
  logic        align_r, align_nxt;
  logic [16:0] run_full;
  logic [15:0] window;
  logic        fits;
  logic        free;

  assign run_full = (17'd1 << size_r) - 17'd1;
  assign window   = run_full[15:0] << pos_r[3:0];
  assign fits     = ({1'b0, pos_r} + {1'b0, size_r}) <= 6'(aala_pkg::FLOAT_REGS);
  assign free     = (used_mask & window) == 16'd0;

  always_comb begin
    stat.done   = busy_r && (!fits || free);
    stat.found  = busy_r && fits && free;
    stat.index  = pos_r[3:0];
    stat.window = window;
  end

  always_comb begin
    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    size_nxt  = size_r;
    align_nxt = align_r;
    if (cmd.start) begin
      busy_nxt  = 1'b1;
      pos_nxt   = 5'd0;
      size_nxt  = cmd.size;
      align_nxt = cmd.align_64;
    end else if (busy_r) begin
      if (stat.done) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + (align_r ? 5'd2 : 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    pos_r   <= pos_nxt;
    size_r  <= size_nxt;
    align_r <= align_nxt;
  end

endmodule

[src/aala_place.sv]
// General register and stack placement, and the stack fallback of float arguments.
module aala_place (
  input  aala_pkg::req_t         req,
  input  aala_pkg::alloc_state_t cur,
  output aala_pkg::res_t         res,
  output aala_pkg::alloc_state_t nxt
);

  localparam logic [2:0]  GR    = 3'(aala_pkg::GEN_REGS);
  localparam logic [10:0] STK_F = 11'(aala_pkg::MAX_STACK_SLOTS);

  always_comb begin
    logic [2:0]  g;
    logic [10:0] st;
    logic [6:0]  n;
    logic [2:0]  avail;
    logic [2:0]  gc;
    logic [11:0] stk_end;
    res     = '0;
    nxt     = cur;
    n       = req.slot_count;
    g       = cur.next_gen_reg;
    st      = cur.next_stack_slot;
    avail   = 3'd0;
    gc      = 3'd0;
    stk_end = 12'd0;
    if (n != 7'd0) begin
      if (req.is_float) begin
        // No register run was free: the whole float bank is closed.
        nxt.float_used_mask = 16'hFFFF;
        if (req.align_64) begin
          st = aala_pkg::align_slot(st);
        end
      end else begin
        if (req.align_64) begin
          if (g < GR) begin
            g = (g + 3'd1) & ~3'd1;
          end
          if (g >= GR) begin
            st = aala_pkg::align_slot(st);
          end
        end
        // An argument does not split once the stack holds anything.
        if (g < GR && n > {4'b0, GR - g} && st != 11'd0) begin
          g = GR;
        end
        if (g < GR) begin
          avail             = GR - g;
          gc                = (n < {4'b0, avail}) ? n[2:0] : avail;
          res.gen_reg_valid = 1'b1;
          res.gen_reg_index = g[1:0];
          res.gen_reg_count = gc;
          g                 = g + gc;
          n                 = n - {4'b0, gc};
        end
      end
      if (n != 7'd0) begin
        res.stack_valid      = 1'b1;
        res.stack_slot_index = (st > STK_F - 11'd1) ? 10'(STK_F - 11'd1) : st[9:0];
        res.stack_slot_count = n;
        stk_end              = {1'b0, st} + {5'b0, n};
        if (stk_end > {1'b0, STK_F}) begin
          res.stack_overflow = 1'b1;
          st                 = STK_F;
        end else begin
          st = stk_end[10:0];
        end
      end
      nxt.next_gen_reg    = g;
      nxt.next_stack_slot = st;
    end
  end

endmodule

[src/aala_checker.sv]
`include "abi_argument_location_allocator_top_defines.svh"

module aala_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result must hold.
  `AALA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // One argument at a time: after a request is taken the input closes.
  `AALA_ASSERT(a_busy_after_take, in_tvalid && in_tready |=> !in_tready, "input open while argument in progress")

  // Float fields read zero when no float registers were assigned.
  `AALA_ASSERT(a_float_zero, out_tvalid && !out_tdata[0] |-> out_tdata[9:1] == 9'd0, "float fields set without float placement")

  // Stack fields read zero when nothing went to the stack.
  `AALA_ASSERT(a_stack_zero, out_tvalid && !out_tdata[16] |-> out_tdata[34:17] == 18'd0, "stack fields set without stack placement")

  // Reset drops any pending result.
  `AALA_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind abi_argument_location_allocator_top aala_checker u_aala_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/arg_location_checker.sv]
module arg_location_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);

  logic [15:0]     fregs_used;
  int              gen_next;
  int              stack_next;
  aala_pkg::res_t  expected_places[$];

  function automatic int even_slot(input int s);
    int a;
    a = (s + 1) & ~1;
    return (a > aala_pkg::MAX_STACK_SLOTS) ? aala_pkg::MAX_STACK_SLOTS : a;
  endfunction

  // The reported start is clamped to the last slot; the pointer saturates.
  task automatic spill_to_stack(input int n, inout aala_pkg::res_t r);
    int last;
    last = stack_next + n;
    r.stack_valid      = 1'b1;
    r.stack_slot_index = 10'((stack_next > aala_pkg::MAX_STACK_SLOTS - 1)
                             ? aala_pkg::MAX_STACK_SLOTS - 1 : stack_next);
    r.stack_slot_count = 7'(n);
    if (last > aala_pkg::MAX_STACK_SLOTS) begin
      r.stack_overflow = 1'b1;
      last = aala_pkg::MAX_STACK_SLOTS;
    end
    stack_next = last;
  endtask

  task automatic place_arg(input logic fresh, input logic [6:0] size_raw,
                           input logic fp, input logic wide, output aala_pkg::res_t r);
    int          n;
    int          s;
    int          stride;
    int          take;
    logic [15:0] run;
    logic [15:0] win;
    bit          hit;
    r = '0;
    if (fresh) begin
      fregs_used = '0;
      gen_next   = 0;
      stack_next = 0;
    end
    n = size_raw;
    if (n == 0) return;
    if (n > aala_pkg::MAX_ARG_SLOTS) n = aala_pkg::MAX_ARG_SLOTS;

    if (fp) begin
      hit = 1'b0;
      if (n <= aala_pkg::FLOAT_REGS) begin
        stride = wide ? 2 : 1;
        run    = 16'((32'd1 << n) - 1);
        for (s = 0; s + n <= aala_pkg::FLOAT_REGS && !hit; s += stride) begin
          win = run << s;
          if ((fregs_used & win) == '0) begin
            fregs_used        |= win;
            r.float_reg_valid = 1'b1;
            r.float_reg_index = 4'(s);
            r.float_reg_count = 5'(n);
            hit               = 1'b1;
          end
        end
      end
      if (!hit) begin
        // No free run: the whole float file is retired for this call.
        fregs_used = '1;
        if (wide) stack_next = even_slot(stack_next);
        spill_to_stack(n, r);
      end
      return;
    end

    if (wide) begin
      if (gen_next < aala_pkg::GEN_REGS) gen_next = (gen_next + 1) & ~1;
      if (gen_next >= aala_pkg::GEN_REGS) stack_next = even_slot(stack_next);
    end
    // Once anything sits on the stack, a general argument may not split.
    if (gen_next < aala_pkg::GEN_REGS && n > aala_pkg::GEN_REGS - gen_next &&
        stack_next != 0)
      gen_next = aala_pkg::GEN_REGS;
    if (gen_next < aala_pkg::GEN_REGS) begin
      take            = (n < aala_pkg::GEN_REGS - gen_next) ? n
                                                             : aala_pkg::GEN_REGS - gen_next;
      r.gen_reg_valid = 1'b1;
      r.gen_reg_index = 2'(gen_next);
      r.gen_reg_count = 3'(take);
      gen_next       += take;
      n              -= take;
    end
    if (n > 0) spill_to_stack(n, r);
  endtask

  task automatic note_failure(input string what, input aala_pkg::res_t want,
                              input logic [39:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s expected %p (%h) got %p (%h)", $realtime, what, want,
               {5'b0, want}, aala_pkg::res_t'(got[34:0]), got);
  endtask

  always @(posedge clk) begin
    aala_pkg::res_t want;
    aala_pkg::res_t placed;
    if (!rst_n) begin
      fregs_used    = '0;
      gen_next      = 0;
      stack_next    = 0;
      fail_count    = 0;
      pending_count = 0;
      expected_places.delete();
    end else begin
      // The result leaving now always belongs to an earlier request.
      if (out_tvalid && out_tready) begin
        if (expected_places.size() == 0) begin
          note_failure("unexpected result:", '0, out_tdata);
        end else begin
          want = expected_places.pop_front();
          if (out_tdata !== {5'b0, want}) note_failure("placement mismatch:", want, out_tdata);
        end
      end
      if (in_tvalid && in_tready) begin
        place_arg(in_tuser[0], in_tdata[6:0], in_tuser[1], in_tuser[2], placed);
        expected_places.push_back(placed);
      end
      pending_count = expected_places.size();
    end
  end

endmodule

[tb/abi_argument_location_allocator_top_tb.sv]
module abi_argument_location_allocator_top_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int fail_count;
  int pending_count;

  // Idle chances in percent per cycle for each side, and the item count so far.
  int send_idle;
  int recv_stall;
  int items_sent;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req;

  abi_argument_location_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  arg_location_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver side. Ready changes on the falling edge only. A hold-off keeps
  // ready low so that the output register fills, the next request finishes
  // behind it, and the block stops taking input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready = ($urandom_range(99) >= recv_stall);
    end
  end

  // Offers one argument request and returns on the falling edge after the
  // handshake. Random idle cycles come first.
  task automatic push_arg(input logic fresh, input logic [6:0] slots,
                          input logic fp, input logic wide);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {1'b0, slots};
    in_tuser  = {wide, fp, fresh};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly register-sized arguments; some mid-sized and large ones, and now
  // and then a zero or an oversized request that gets clamped.
  function automatic logic [6:0] pick_size(input bit heavy);
    int r;
    r = $urandom_range(99);
    if (heavy) return (r < 75) ? 7'($urandom_range(32, 64)) : 7'($urandom_range(65, 127));
    if (r < 60) return 7'($urandom_range(1, 4));
    if (r < 85) return 7'($urandom_range(1, 16));
    if (r < 95) return 7'($urandom_range(17, 64));
    return $urandom_range(1) ? 7'd0 : 7'($urandom_range(65, 127));
  endfunction

  // One call: a first argument that clears the state, then any further arguments.
  // About one call in ten is long and heavy, which walks the stack pointer
  // up to its limit and into saturation. A few arguments restart the call
  // early to break the sequence.
  task automatic random_call();
    int  len;
    bit  heavy;
    heavy = ($urandom_range(9) == 0);
    len   = heavy ? $urandom_range(20, 40) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++)
      push_arg((i == 0) || ($urandom_range(99) < 3), pick_size(heavy),
               1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic calls_until(input int goal);
    while (items_sent < goal) random_call();
  endtask

  // The sender stops until every outstanding result has come back.
  task automatic drain_pause();
    in_tvalid = 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    send_idle  = 0;
    recv_stall = 0;
    items_sent = 0;
    hold_req   = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Float runs: single, aligned pair, backfill of the hole, then a run
    // that no longer fits and spills, retiring the whole float file.
    push_arg(1'b1, 7'd1,   1'b1, 1'b0);
    push_arg(1'b0, 7'd2,   1'b1, 1'b1);
    push_arg(1'b0, 7'd1,   1'b1, 1'b0);
    push_arg(1'b0, 7'd15,  1'b1, 1'b0);
    // A run that reaches the top register exactly, then a zero-size request.
    push_arg(1'b1, 7'd16,  1'b1, 1'b1);
    push_arg(1'b0, 7'd0,   1'b1, 1'b0);
    // General registers: plain, aligned pair, then the stack with alignment.
    push_arg(1'b1, 7'd1,   1'b0, 1'b0);
    push_arg(1'b0, 7'd2,   1'b0, 1'b1);
    push_arg(1'b0, 7'd1,   1'b0, 1'b0);
    push_arg(1'b0, 7'd2,   1'b0, 1'b1);
    // An oversized argument clamps and splits between registers and stack.
    push_arg(1'b1, 7'd3,   1'b0, 1'b0);
    push_arg(1'b0, 7'd127, 1'b0, 1'b0);
    push_arg(1'b0, 7'd2,   1'b0, 1'b0);
    // A float too large for the registers, then a general argument that may
    // not split because the stack is already in use.
    push_arg(1'b1, 7'd17,  1'b1, 1'b1);
    push_arg(1'b0, 7'd5,   1'b0, 1'b0);
    push_arg(1'b0, 7'd3,   1'b0, 1'b1);
    push_arg(1'b1, 7'd65,  1'b1, 1'b0);

    // No idling, with one long receiver hold-off in the middle.
    calls_until(300);
    hold_req = 1'b1;
    calls_until(500);

    // Sender mostly idle, with one full drain.
    send_idle = 64;
    calls_until(750);
    drain_pause();
    calls_until(1000);

    // Receiver mostly stalled.
    send_idle  = 0;
    recv_stall = 64;
    calls_until(1500);

    // Light idling on both sides.
    send_idle  = 8;
    recv_stall = 8;
    calls_until(2000);

    in_tvalid = 1'b0;
    wait (pending_count == 0);
    // The wait below covers any stray result.
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout for the worst run: about 2100 requests, plus sender gaps,
  // receiver stalls and the hold-off.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
